>>> rtl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg: build script lexer shared definitions
// Lexer modes, token kinds, error codes, character codes and keyword tables.
// ----------------------------------------------------------------------------
package bsl_pkg;

    // lexer modes, one-hot
    typedef enum logic [7:0] {
        LX_NORMAL    = 8'b0000_0001,
        LX_IDENT     = 8'b0000_0010,
        LX_STRING    = 8'b0000_0100,
        LX_SLASH     = 8'b0000_1000,
        LX_LINECOM   = 8'b0001_0000,
        LX_BLOCK     = 8'b0010_0000,
        LX_BLOCKSTAR = 8'b0100_0000,
        LX_DISCARD   = 8'b1000_0000
    } lex_mode_t;

    // token kinds
    localparam logic [4:0] KIND_DOT     = 5'd0;
    localparam logic [4:0] KIND_ASSIGN  = 5'd1;
    localparam logic [4:0] KIND_LCURLY  = 5'd2;
    localparam logic [4:0] KIND_RCURLY  = 5'd3;
    localparam logic [4:0] KIND_LPAREN  = 5'd4;
    localparam logic [4:0] KIND_RPAREN  = 5'd5;
    localparam logic [4:0] KIND_BANG    = 5'd6;
    localparam logic [4:0] KIND_PROJECT = 5'd7;
    localparam logic [4:0] KIND_LIBRARY = 5'd8;
    localparam logic [4:0] KIND_RECURSE = 5'd9;
    localparam logic [4:0] KIND_STATIC  = 5'd10;
    localparam logic [4:0] KIND_DYNAMIC = 5'd11;
    localparam logic [4:0] KIND_TRUE    = 5'd12;
    localparam logic [4:0] KIND_FALSE   = 5'd13;
    localparam logic [4:0] KIND_IF      = 5'd14;
    localparam logic [4:0] KIND_ELSE    = 5'd15;
    localparam logic [4:0] KIND_STRING  = 5'd16;
    localparam logic [4:0] KIND_IDENT   = 5'd17;
    localparam logic [4:0] KIND_END     = 5'd18;

    // error codes
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR    = 2'd1;
    localparam logic [1:0] ERR_OPEN_STRING = 2'd2;
    localparam logic [1:0] ERR_OPEN_BLOCK  = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;

    localparam logic [15:0] LINE_MAX = 16'hFFFF;
    localparam logic [3:0]  ILEN_MAX = 4'd15;

    // keyword tables
    localparam int NUM_KW = 10;
    localparam int KW_MAX = 9;
    localparam logic [NUM_KW-1:0] KW_ALL = '1;

    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX] = '{
        '{"P", "r", "o", "j", "e", "c", "t", CH_NUL, CH_NUL},
        '{"L", "i", "b", "r", "a", "r", "y", CH_NUL, CH_NUL},
        '{"r", "e", "c", "u", "r", "s", "i", "v", "e"},
        '{"i", "t", "e", "r", "a", "t", "e", CH_NUL, CH_NUL},
        '{"s", "t", "a", "t", "i", "c", CH_NUL, CH_NUL, CH_NUL},
        '{"d", "y", "n", "a", "m", "i", "c", CH_NUL, CH_NUL},
        '{"t", "r", "u", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"f", "a", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"e", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd7, 4'd7, 4'd9, 4'd7, 4'd6, 4'd7, 4'd4, 4'd5, 4'd2, 4'd4
    };
    localparam logic [4:0] KW_KIND [NUM_KW] = '{
        KIND_PROJECT, KIND_LIBRARY, KIND_RECURSE, KIND_RECURSE, KIND_STATIC,
        KIND_DYNAMIC, KIND_TRUE, KIND_FALSE, KIND_IF, KIND_ELSE
    };

    // one result beat
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [15:0] line;
        logic [1:0]  err;
        logic [7:0]  bad;
        logic        last;
    } result_t;

    function automatic result_t make_result(input logic [4:0] kind,
                                            input logic [15:0] start,
                                            input logic [15:0] length,
                                            input logic [15:0] line,
                                            input logic [1:0] err,
                                            input logic [7:0] bad);
        result_t r;
        r.kind   = kind;
        r.start  = start;
        r.length = length;
        r.line   = line;
        r.err    = err;
        r.bad    = bad;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9");
    endfunction

    // drop keywords that cannot match once char c sits at offset idx
    function automatic logic [NUM_KW-1:0] kw_match(input logic [NUM_KW-1:0] mask,
                                                   input logic [3:0] idx,
                                                   input logic [7:0] c);
        logic [NUM_KW-1:0] m;
        m = mask;
        for (int k = 0; k < NUM_KW; k++) begin
            if (idx >= KW_LEN[k]) begin
                m[k] = 1'b0;
            end else if (KW_TEXT[k][idx] != c) begin
                m[k] = 1'b0;
            end
        end
        return m;
    endfunction

    // first surviving keyword of the right length, else identifier
    function automatic logic [4:0] ident_kind(input logic [NUM_KW-1:0] mask,
                                              input logic [3:0] len);
        logic [4:0] kind;
        kind = KIND_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (mask[k] && KW_LEN[k] == len) begin
                kind = KW_KIND[k];
            end
        end
        return kind;
    endfunction

endpackage

>>> rtl/build_script_lexer_unit.sv
// ----------------------------------------------------------------------------
// build_script_lexer_unit: build script lexer
// Scans source bytes into punctuation, string, identifier, keyword and end tokens.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                  | tuser      | tlast
//  s_      | in  | char_code              | -          | end_of_text
//  m_      | out | start,length,line,err,  | token_kind | last_of_run
//          |     | bad_byte               |            |
//
//  One byte per cycle while the queue has room: an input register feeds the
//  scanner, which commits at most two tokens per byte into a four-entry result queue.
//  Input stalls while the queue has fewer than two free slots; the output
//  moves one beat per cycle, so once the queue backs up each byte that yields
//  two tokens holds the input back, and a stalled sink stalls the input.
//  An input beat passes the input register, then the result queue, to the output.
//  Reset (aresetn low, synchronous) empties both stages and restarts scanning.
//  An end-of-text beat (or a zero byte) also restarts the scanner state.
// ----------------------------------------------------------------------------
module build_script_lexer_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] start, [31:16] length, [47:32] line,
                                   // [49:48] error_code, [57:50] bad_byte
    output logic [4:0]  m_tuser,   // [4:0] token_kind
    output logic        m_tlast
);

    localparam int QDEPTH = 4;
    localparam int QBITS  = $clog2(QDEPTH);

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_eot_reg;

    // scanner state
    bsl_pkg::lex_mode_t            mode_reg, mode_next;
    logic [POSITION_BITS-1:0]      pos_reg, pos_next;
    logic [POSITION_BITS-1:0]      tbegin_reg, tbegin_next;
    logic [15:0]                   line_reg, line_next;
    logic [15:0]                   tline_reg, tline_next;
    logic [bsl_pkg::NUM_KW-1:0]    mask_reg, mask_next;
    logic [3:0]                    ilen_reg, ilen_next;

    // result queue
    bsl_pkg::result_t  queue_reg [QDEPTH];
    logic [QBITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QBITS:0]    count_reg;

    logic                     fire, pop, eot;
    logic                     to_normal;
    logic [POSITION_BITS-1:0] len;
    logic [15:0]              pos16;
    bsl_pkg::result_t         res_a, res_b, slot0, slot1;
    logic                     va, vb;
    logic [1:0]               n_push;

    assign fire     = in_valid_reg && (count_reg <= (QBITS+1)'(QDEPTH - 2));
    assign s_tready = !in_valid_reg || fire;
    assign pop      = m_tvalid && m_tready;

    assign eot   = in_eot_reg || (in_char_reg == bsl_pkg::CH_NUL);
    assign len   = pos_reg - tbegin_reg;
    assign pos16 = 16'(pos_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    // scanner: mode handling gives res_a, the fresh-byte path gives res_b
    always_comb begin
        mode_next   = mode_reg;
        tbegin_next = tbegin_reg;
        line_next   = line_reg;
        tline_next  = tline_reg;
        mask_next   = mask_reg;
        ilen_next   = ilen_reg;
        to_normal   = 1'b0;
        va          = 1'b0;
        vb          = 1'b0;
        res_a       = '0;
        res_b       = '0;

        unique case (mode_reg)
            bsl_pkg::LX_IDENT: begin
                if (eot || !bsl_pkg::is_ident(in_char_reg)) begin
                    va        = 1'b1;
                    res_a     = bsl_pkg::make_result(
                                    bsl_pkg::ident_kind(mask_reg, ilen_reg),
                                    16'(tbegin_reg), 16'(len), tline_reg,
                                    bsl_pkg::ERR_NONE, 8'h00);
                    mode_next = bsl_pkg::LX_NORMAL;
                    to_normal = 1'b1;
                end else begin
                    mask_next = bsl_pkg::kw_match(mask_reg, ilen_reg, in_char_reg);
                    ilen_next = (ilen_reg == bsl_pkg::ILEN_MAX) ? ilen_reg
                                                                : ilen_reg + 4'd1;
                end
            end
            bsl_pkg::LX_STRING: begin
                if (eot) begin
                    va    = 1'b1;
                    res_a = bsl_pkg::make_result(bsl_pkg::KIND_END, 16'(tbegin_reg),
                                16'(len), tline_reg, bsl_pkg::ERR_OPEN_STRING, 8'h00);
                end else if (in_char_reg == bsl_pkg::CH_DQUOTE) begin
                    va        = 1'b1;
                    res_a     = bsl_pkg::make_result(bsl_pkg::KIND_STRING,
                                    16'(tbegin_reg), 16'(len), tline_reg,
                                    bsl_pkg::ERR_NONE, 8'h00);
                    mode_next = bsl_pkg::LX_NORMAL;
                end
            end
            bsl_pkg::LX_SLASH: begin
                if (!eot && in_char_reg == bsl_pkg::CH_SLASH) begin
                    mode_next = bsl_pkg::LX_LINECOM;
                end else if (!eot && in_char_reg == bsl_pkg::CH_STAR) begin
                    mode_next = bsl_pkg::LX_BLOCK;
                end else begin
                    // lone slash
                    va        = 1'b1;
                    res_a     = bsl_pkg::make_result(bsl_pkg::KIND_END,
                                    16'(tbegin_reg), 16'd0, tline_reg,
                                    bsl_pkg::ERR_BAD_CHAR, bsl_pkg::CH_SLASH);
                    mode_next = bsl_pkg::LX_DISCARD;
                end
            end
            bsl_pkg::LX_LINECOM: begin
                if (eot || in_char_reg == bsl_pkg::CH_LF) begin
                    mode_next = bsl_pkg::LX_NORMAL;
                    to_normal = 1'b1;
                end
            end
            bsl_pkg::LX_BLOCK, bsl_pkg::LX_BLOCKSTAR: begin
                if (eot) begin
                    va    = 1'b1;
                    res_a = bsl_pkg::make_result(bsl_pkg::KIND_END, 16'(tbegin_reg),
                                16'd0, tline_reg, bsl_pkg::ERR_OPEN_BLOCK, 8'h00);
                end else if (mode_reg == bsl_pkg::LX_BLOCKSTAR &&
                             in_char_reg == bsl_pkg::CH_SLASH) begin
                    mode_next = bsl_pkg::LX_NORMAL;
                end else if (in_char_reg == bsl_pkg::CH_STAR) begin
                    mode_next = bsl_pkg::LX_BLOCKSTAR;
                end else begin
                    mode_next = bsl_pkg::LX_BLOCK;
                end
            end
            bsl_pkg::LX_DISCARD: begin
            end
            default: begin
                to_normal = 1'b1;
            end
        endcase

        if (to_normal) begin
            if (eot) begin
                vb    = 1'b1;
                res_b = bsl_pkg::make_result(bsl_pkg::KIND_END, pos16, 16'd0,
                            line_reg, bsl_pkg::ERR_NONE, 8'h00);
            end else begin
                case (in_char_reg) inside
                    bsl_pkg::CH_SEMI, bsl_pkg::CH_COMMA,
                    bsl_pkg::CH_SPACE, bsl_pkg::CH_TAB, bsl_pkg::CH_CR,
                    bsl_pkg::CH_FF, bsl_pkg::CH_VT: begin
                    end
                    bsl_pkg::CH_HASH: begin
                        mode_next = bsl_pkg::LX_LINECOM;
                    end
                    bsl_pkg::CH_SLASH: begin
                        tbegin_next = pos_reg;
                        tline_next  = line_reg;
                        mode_next   = bsl_pkg::LX_SLASH;
                    end
                    bsl_pkg::CH_DQUOTE: begin
                        tbegin_next = pos_reg + POSITION_BITS'(1);
                        tline_next  = line_reg;
                        mode_next   = bsl_pkg::LX_STRING;
                    end
                    bsl_pkg::CH_LF: begin
                        if (line_reg != bsl_pkg::LINE_MAX) begin
                            line_next = line_reg + 16'd1;
                        end
                    end
                    bsl_pkg::CH_DOT: begin
                        vb    = 1'b1;
                        res_b = bsl_pkg::make_result(bsl_pkg::KIND_DOT, pos16, 16'd1,
                                    line_reg, bsl_pkg::ERR_NONE, 8'h00);
                    end
                    bsl_pkg::CH_EQUALS: begin
                        vb    = 1'b1;
                        res_b = bsl_pkg::make_result(bsl_pkg::KIND_ASSIGN, pos16, 16'd1,
                                    line_reg, bsl_pkg::ERR_NONE, 8'h00);
                    end
                    bsl_pkg::CH_LCURLY: begin
                        vb    = 1'b1;
                        res_b = bsl_pkg::make_result(bsl_pkg::KIND_LCURLY, pos16, 16'd1,
                                    line_reg, bsl_pkg::ERR_NONE, 8'h00);
                    end
                    bsl_pkg::CH_RCURLY: begin
                        vb    = 1'b1;
                        res_b = bsl_pkg::make_result(bsl_pkg::KIND_RCURLY, pos16, 16'd1,
                                    line_reg, bsl_pkg::ERR_NONE, 8'h00);
                    end
                    bsl_pkg::CH_LPAREN: begin
                        vb    = 1'b1;
                        res_b = bsl_pkg::make_result(bsl_pkg::KIND_LPAREN, pos16, 16'd1,
                                    line_reg, bsl_pkg::ERR_NONE, 8'h00);
                    end
                    bsl_pkg::CH_RPAREN: begin
                        vb    = 1'b1;
                        res_b = bsl_pkg::make_result(bsl_pkg::KIND_RPAREN, pos16, 16'd1,
                                    line_reg, bsl_pkg::ERR_NONE, 8'h00);
                    end
                    bsl_pkg::CH_BANG: begin
                        vb    = 1'b1;
                        res_b = bsl_pkg::make_result(bsl_pkg::KIND_BANG, pos16, 16'd1,
                                    line_reg, bsl_pkg::ERR_NONE, 8'h00);
                    end
                    default: begin
                        if (bsl_pkg::is_alpha(in_char_reg)) begin
                            tbegin_next = pos_reg;
                            tline_next  = line_reg;
                            mask_next   = bsl_pkg::kw_match(bsl_pkg::KW_ALL, 4'd0,
                                                            in_char_reg);
                            ilen_next   = 4'd1;
                            mode_next   = bsl_pkg::LX_IDENT;
                        end else begin
                            vb        = 1'b1;
                            res_b     = bsl_pkg::make_result(bsl_pkg::KIND_END, pos16,
                                            16'd0, line_reg, bsl_pkg::ERR_BAD_CHAR,
                                            in_char_reg);
                            mode_next = bsl_pkg::LX_DISCARD;
                        end
                    end
                endcase
            end
        end

        // every end mark restarts the scanner, whatever the mode
        if (eot) begin
            mode_next   = bsl_pkg::LX_NORMAL;
            pos_next    = '0;
            tbegin_next = '0;
            line_next   = 16'd1;
            tline_next  = 16'd1;
            mask_next   = bsl_pkg::KW_ALL;
            ilen_next   = 4'd0;
        end else begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    // pack up to two results, last flag on the final one
    always_comb begin
        slot0  = va ? res_a : res_b;
        slot1  = res_b;
        n_push = {1'b0, va} + {1'b0, vb};
        slot0.last = !(va && vb);
        slot1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= bsl_pkg::LX_NORMAL;
            pos_reg    <= '0;
            tbegin_reg <= '0;
            line_reg   <= 16'd1;
            tline_reg  <= 16'd1;
            mask_reg   <= bsl_pkg::KW_ALL;
            ilen_reg   <= 4'd0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tbegin_reg <= tbegin_next;
            line_reg   <= line_next;
            tline_reg  <= tline_next;
            mask_reg   <= mask_next;
            ilen_reg   <= ilen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && n_push != 2'd0) begin
            queue_reg[wr_ptr_reg] <= slot0;
        end
        if (fire && n_push == 2'd2) begin
            queue_reg[wr_ptr_reg + QBITS'(1)] <= slot1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (fire) begin
                wr_ptr_reg <= wr_ptr_reg + QBITS'(n_push);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QBITS'(1);
            end
            count_reg <= count_reg + (QBITS+1)'(fire ? n_push : 2'd0)
                                   - (QBITS+1)'(pop);
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tuser  = queue_reg[rd_ptr_reg].kind;
    assign m_tlast  = queue_reg[rd_ptr_reg].last;
    assign m_tdata  = {6'd0,
                       queue_reg[rd_ptr_reg].bad,
                       queue_reg[rd_ptr_reg].err,
                       queue_reg[rd_ptr_reg].line,
                       queue_reg[rd_ptr_reg].length,
                       queue_reg[rd_ptr_reg].start};

    // queue never overfills
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QBITS+1)'(QDEPTH))
        else $error("result queue overflow");

    // an end-of-text beat leaves the scanner at its start state
    a_eot_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && eot) |=> (pos_reg == '0 && line_reg == 16'd1 &&
                           mode_reg == bsl_pkg::LX_NORMAL))
        else $error("scanner not restarted after end of text");

    // an identifier in progress always has at least one byte
    a_ident_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == bsl_pkg::LX_IDENT) |-> (ilen_reg != 4'd0))
        else $error("identifier mode with empty identifier");

    // reset returns the scanner to normal mode at position zero
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (mode_reg == bsl_pkg::LX_NORMAL && pos_reg == '0 &&
                      count_reg == '0))
        else $error("bad state after reset");

endmodule
